// File: design/xml_tag_tokenizer_checker_core_defines.svh
// ----------------------------------------------------------------------------
// xml tag tokenizer checker assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef XML_TAG_TOKENIZER_CHECKER_CORE_DEFINES_SVH
`define XML_TAG_TOKENIZER_CHECKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define XTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xtc assertion failed");
`define XTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xtc assertion failed");
`else
`define XTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define XTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/xtc_pkg.sv
// ----------------------------------------------------------------------------
// xml tag tokenizer checker package
// token, grammar and lexer codes, result types and the per-byte step function
// ----------------------------------------------------------------------------
package xtc_pkg;

    localparam int unsigned MAX_RES = 3;

    // lexer modes
    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_LT    = 3'd1;
    localparam logic [2:0] M_SLASH = 3'd2;
    localparam logic [2:0] M_QMARK = 3'd3;
    localparam logic [2:0] M_NAME  = 3'd4;
    localparam logic [2:0] M_TEXT  = 3'd5;

    // grammar positions
    localparam logic [3:0] G_PROLOG = 4'd0;
    localparam logic [3:0] G_PI     = 4'd1;
    localparam logic [3:0] G_FIRST  = 4'd2;
    localparam logic [3:0] G_NODE   = 4'd3;
    localparam logic [3:0] G_TNAME  = 4'd4;
    localparam logic [3:0] G_ATTR   = 4'd5;
    localparam logic [3:0] G_EQ     = 4'd6;
    localparam logic [3:0] G_VAL    = 4'd7;
    localparam logic [3:0] G_ENAME  = 4'd8;
    localparam logic [3:0] G_ECLOSE = 4'd9;

    // token kinds
    localparam logic [3:0] K_TAG_OPEN = 4'd0;
    localparam logic [3:0] K_END_OPEN = 4'd1;
    localparam logic [3:0] K_PI_OPEN  = 4'd2;
    localparam logic [3:0] K_PI_CLOSE = 4'd3;
    localparam logic [3:0] K_CLOSE    = 4'd4;
    localparam logic [3:0] K_EMPTY    = 4'd5;
    localparam logic [3:0] K_EQUALS   = 4'd6;
    localparam logic [3:0] K_NAME_CH  = 4'd7;
    localparam logic [3:0] K_NAME_END = 4'd8;
    localparam logic [3:0] K_TEXT_CH  = 4'd9;
    localparam logic [3:0] K_TEXT_END = 4'd10;
    localparam logic [3:0] K_END      = 4'd11;
    localparam logic [3:0] K_ERROR    = 4'd12;

    // syntax error codes
    localparam logic [3:0] E_NONE       = 4'd0;
    localparam logic [3:0] E_OPENER     = 4'd1;
    localparam logic [3:0] E_TAG_NAME   = 4'd2;
    localparam logic [3:0] E_EQUALS     = 4'd3;
    localparam logic [3:0] E_VALUE      = 4'd4;
    localparam logic [3:0] E_CLOSER     = 4'd5;
    localparam logic [3:0] E_END_NAME   = 4'd6;
    localparam logic [3:0] E_END_CLOSER = 4'd7;
    localparam logic [3:0] E_STRAY      = 4'd8;

    // characters
    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_LT    = 8'h3C;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_QMARK = 8'h3F;
    localparam logic [7:0] C_UP_A  = 8'h41;
    localparam logic [7:0] C_UP_Z  = 8'h5A;
    localparam logic [7:0] C_LO_A  = 8'h61;
    localparam logic [7:0] C_LO_Z  = 8'h7A;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic [3:0] err;
    } t_res;

    typedef struct packed {
        logic [2:0]             mode;
        logic [3:0]             gpos;
        logic                   fin;
        logic [1:0]             cnt;
        t_res [MAX_RES-1:0]     res;
    } t_step;

    typedef struct packed {
        logic [3:0] next;
        logic [3:0] code;
    } t_acc;

    function automatic logic f_is_alpha(input logic [7:0] b);
        return ((b >= C_UP_A) && (b <= C_UP_Z)) || ((b >= C_LO_A) && (b <= C_LO_Z));
    endfunction

    function automatic logic f_is_space(input logic [7:0] b);
        return (b == C_SPACE) || ((b >= C_TAB) && (b <= C_CR));
    endfunction

    // grammar check at the start of a token
    function automatic t_acc f_accept(input logic [3:0] gpos, input logic [3:0] k);
        t_acc a;
        a.next = gpos;
        a.code = E_NONE;
        case (gpos)
            G_PROLOG: begin
                if (k == K_PI_OPEN) a.next = G_PI;
                else if (k == K_TAG_OPEN) a.next = G_TNAME;
                else if (k == K_END_OPEN) a.next = G_ENAME;
                else a.code = E_OPENER;
            end
            G_PI: begin
                if (k == K_PI_CLOSE) a.next = G_FIRST;
            end
            G_FIRST, G_NODE: begin
                if (k == K_TAG_OPEN) a.next = G_TNAME;
                else if (k == K_END_OPEN) a.next = G_ENAME;
                else a.code = E_OPENER;
            end
            G_TNAME: begin
                if (k == K_NAME_CH) a.next = G_ATTR;
                else a.code = E_TAG_NAME;
            end
            G_ATTR: begin
                if (k == K_NAME_CH) a.next = G_EQ;
                else if ((k == K_CLOSE) || (k == K_EMPTY)) a.next = G_NODE;
                else a.code = E_CLOSER;
            end
            G_EQ: begin
                if (k == K_EQUALS) a.next = G_VAL;
                else a.code = E_EQUALS;
            end
            G_VAL: begin
                if (k == K_TEXT_CH) a.next = G_ATTR;
                else a.code = E_VALUE;
            end
            G_ENAME: begin
                if (k == K_NAME_CH) a.next = G_ECLOSE;
                else a.code = E_END_NAME;
            end
            G_ECLOSE: begin
                if (k == K_CLOSE) a.next = G_NODE;
                else a.code = E_END_CLOSER;
            end
            default: begin
                a.code = E_OPENER;
            end
        endcase
        return a;
    endfunction

    function automatic logic [3:0] f_eof_code(input logic [3:0] gpos);
        logic [3:0] c;
        case (gpos)
            G_PI:     c = E_CLOSER;
            G_TNAME:  c = E_TAG_NAME;
            G_ATTR:   c = E_CLOSER;
            G_EQ:     c = E_EQUALS;
            G_VAL:    c = E_VALUE;
            G_ENAME:  c = E_END_NAME;
            G_ECLOSE: c = E_END_CLOSER;
            default:  c = E_OPENER;
        endcase
        return c;
    endfunction

    function automatic t_step f_emit(input t_step s, input logic [3:0] k,
                                     input logic [7:0] c, input logic [3:0] e);
        t_step r;
        r = s;
        if (r.cnt < 2'(MAX_RES)) begin
            r.res[r.cnt].kind = k;
            r.res[r.cnt].ch   = c;
            r.res[r.cnt].err  = e;
            r.cnt             = r.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic t_step f_fail(input t_step s, input logic [3:0] code);
        t_step r;
        r      = s;
        r.fin  = 1'b1;
        r.mode = M_IDLE;
        return f_emit(r, K_ERROR, C_NUL, code);
    endfunction

    function automatic t_step f_token(input t_step s, input logic [3:0] k);
        t_acc  a;
        t_step r;
        a = f_accept(s.gpos, k);
        if (a.code != E_NONE) begin
            r = f_fail(s, a.code);
        end else begin
            r      = s;
            r.gpos = a.next;
            r      = f_emit(r, k, C_NUL, E_NONE);
        end
        return r;
    endfunction

    // everything one byte does to the state, and the results it gives
    function automatic t_step f_step(input t_step s, input logic [7:0] b, input logic last);
        t_step      r;
        t_acc       a;
        logic       consumed;
        logic [2:0] m;
        r        = s;
        r.cnt    = 2'd0;
        r.res    = '0;
        consumed = 1'b0;
        m        = s.mode;
        if (!r.fin) begin
            if (b != C_NUL) begin
                case (r.mode)
                    M_LT: begin
                        r.mode = M_IDLE;
                        if (b == C_SLASH) begin
                            r        = f_token(r, K_END_OPEN);
                            consumed = 1'b1;
                        end else if (b == C_QMARK) begin
                            r        = f_token(r, K_PI_OPEN);
                            consumed = 1'b1;
                        end else begin
                            r = f_token(r, K_TAG_OPEN);
                        end
                    end
                    M_SLASH, M_QMARK: begin
                        consumed = 1'b1;
                        if (b == C_GT) begin
                            m      = r.mode;
                            r.mode = M_IDLE;
                            r      = f_token(r, (m == M_SLASH) ? K_EMPTY : K_PI_CLOSE);
                        end else begin
                            r = f_fail(r, E_STRAY);
                        end
                    end
                    M_NAME: begin
                        if (f_is_alpha(b)) begin
                            r        = f_emit(r, K_NAME_CH, b, E_NONE);
                            consumed = 1'b1;
                        end else begin
                            r.mode = M_IDLE;
                            r      = f_emit(r, K_NAME_END, C_NUL, E_NONE);
                        end
                    end
                    M_TEXT: begin
                        consumed = 1'b1;
                        if (b == C_QUOTE) begin
                            r.mode = M_IDLE;
                            r      = f_emit(r, K_TEXT_END, C_NUL, E_NONE);
                        end else begin
                            r = f_emit(r, K_TEXT_CH, b, E_NONE);
                        end
                    end
                    default: begin
                        r.mode = M_IDLE;
                    end
                endcase

                // byte that starts a new token
                if (!consumed && !r.fin && !f_is_space(b)) begin
                    if (f_is_alpha(b)) begin
                        a = f_accept(r.gpos, K_NAME_CH);
                        if (a.code != E_NONE) begin
                            r = f_fail(r, a.code);
                        end else begin
                            r.gpos = a.next;
                            r      = f_emit(r, K_NAME_CH, b, E_NONE);
                            r.mode = M_NAME;
                        end
                    end else if (b == C_QUOTE) begin
                        a = f_accept(r.gpos, K_TEXT_CH);
                        if (a.code != E_NONE) begin
                            r = f_fail(r, a.code);
                        end else begin
                            r.gpos = a.next;
                            r.mode = M_TEXT;
                        end
                    end else if (b == C_EQ) begin
                        r = f_token(r, K_EQUALS);
                    end else if (b == C_GT) begin
                        r = f_token(r, K_CLOSE);
                    end else if (b == C_LT) begin
                        r.mode = M_LT;
                    end else if (b == C_SLASH) begin
                        r.mode = M_SLASH;
                    end else if (b == C_QMARK) begin
                        r.mode = M_QMARK;
                    end else begin
                        r = f_fail(r, E_STRAY);
                    end
                end
            end

            // end of input
            if (!r.fin && ((b == C_NUL) || last)) begin
                m      = r.mode;
                r.mode = M_IDLE;
                if (m == M_TEXT) begin
                    r = f_fail(r, E_VALUE);
                end else if ((m == M_SLASH) || (m == M_QMARK)) begin
                    r = f_fail(r, E_STRAY);
                end else begin
                    if (m == M_LT) begin
                        r = f_token(r, K_TAG_OPEN);
                    end
                    if (!r.fin) begin
                        if (r.gpos == G_NODE) begin
                            r.fin = 1'b1;
                            r     = f_emit(r, K_END, C_NUL, E_NONE);
                        end else begin
                            r = f_fail(r, f_eof_code(r.gpos));
                        end
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

// File: design/xtc_in_if.sv
// ----------------------------------------------------------------------------
// xml tag tokenizer checker input channel
// document bytes with valid/ready handshake
// ----------------------------------------------------------------------------
interface xtc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// File: design/xtc_out_if.sv
// ----------------------------------------------------------------------------
// xml tag tokenizer checker output channel
// token events with valid/ready handshake
// ----------------------------------------------------------------------------
interface xtc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [7:0] token_char;
    logic [3:0] syntax_error;
    logic       last_result;

    modport source (output valid, output token_kind, output token_char,
                    output syntax_error, output last_result, input ready);
    modport sink   (input valid, input token_kind, input token_char,
                    input syntax_error, input last_result, output ready);
endinterface

// File: design/xml_tag_tokenizer_checker_core.sv
// a byte's results are registered and offered in the cycle after its input transfer
// throughput: one byte per cycle while each byte gives at most one result and
// the output is ready; a byte giving n results holds the 3-entry result buffer
// reset: synchronous, active low; clears lexer mode, grammar position,
// finished flag and the result buffer count
// ----------------------------------------------------------------------------
// xml tag tokenizer checker core
// lexes a byte stream into tag tokens and checks a flat tag grammar
// ----------------------------------------------------------------------------
`include "xml_tag_tokenizer_checker_core_defines.svh"

module xml_tag_tokenizer_checker_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xtc_in_if.sink        i_in,
    xtc_out_if.source     o_out
);

    logic [2:0]                          r_mode;
    logic [3:0]                          r_gpos;
    logic                                r_fin;
    logic [1:0]                          r_cnt;
    logic [1:0]                          r_idx;
    xtc_pkg::t_res [xtc_pkg::MAX_RES-1:0] r_res;

    xtc_pkg::t_step w_cur;
    xtc_pkg::t_step n_step;
    logic           w_in_xfer;
    logic           w_out_xfer;
    logic           w_out_last;

    always_comb begin
        w_cur      = '0;
        w_cur.mode = r_mode;
        w_cur.gpos = r_gpos;
        w_cur.fin  = r_fin;
        n_step     = xtc_pkg::f_step(w_cur, i_in.in_byte, i_in.last_byte);
    end

    assign w_out_last = (r_idx == (r_cnt - 2'd1));
    assign w_out_xfer = o_out.valid && o_out.ready;
    // take a new byte once the buffer is empty or its final result leaves now
    assign i_in.ready = (r_cnt == 2'd0) || (o_out.ready && w_out_last);
    assign w_in_xfer  = i_in.valid && i_in.ready;

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.token_kind   = r_res[r_idx].kind;
    assign o_out.token_char   = r_res[r_idx].ch;
    assign o_out.syntax_error = r_res[r_idx].err;
    assign o_out.last_result  = w_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= xtc_pkg::M_IDLE;
            r_gpos <= xtc_pkg::G_PROLOG;
            r_fin  <= 1'b0;
            r_cnt  <= 2'd0;
            r_idx  <= 2'd0;
        end else if (w_in_xfer) begin
            r_mode <= n_step.mode;
            r_gpos <= n_step.gpos;
            r_fin  <= n_step.fin;
            r_cnt  <= n_step.cnt;
            r_idx  <= 2'd0;
        end else if (w_out_xfer) begin
            if (w_out_last) begin
                r_cnt <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_res <= n_step.res;
        end
    end

    `XTC_ASSERT_NXT(a_fin_sticky, i_clk, i_rst_n, r_fin, r_fin)
    `XTC_ASSERT_IMP(a_idx_in_range, i_clk, i_rst_n, r_cnt != 2'd0, r_idx < r_cnt)
    `XTC_ASSERT_IMP(a_error_is_last, i_clk, i_rst_n,
        o_out.valid && (o_out.token_kind == xtc_pkg::K_ERROR), o_out.last_result)
    `XTC_ASSERT_IMP(a_done_means_fin, i_clk, i_rst_n,
        o_out.valid && ((o_out.token_kind == xtc_pkg::K_ERROR) ||
        (o_out.token_kind == xtc_pkg::K_END)), r_fin)
    `XTC_ASSERT_NXT(a_fin_silent, i_clk, i_rst_n, r_fin && w_in_xfer, r_cnt == 2'd0)

endmodule
